// File: hdl/cwa_pkg.sv
// Shared constants and controller state codes for the centered window average.
package cwa_pkg;

  localparam int FIELD_W = 32;          // sample and average field width
  localparam int CFG_W   = 6;           // radius register width
  localparam int CNT_W   = 8;           // saturating sample count
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SUB   = 7'b0000010,
    ST_ADD   = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_EMIT  = 7'b0010000,
    ST_FLUSH = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

endpackage

// File: hdl/cwa_delay_line.sv
// Circular sample store: one write port, one registered read port.
module cwa_delay_line #(
  parameter int ADDR_W = 7,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/cwa_divider.sv
// Bit-serial signed divider: one quotient bit per cycle, truncates toward zero.
module cwa_divider #(
  parameter int SUM_W = 39,
  parameter int DIV_W = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0]        divisor,
  output logic                    done,
  output logic signed [SUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] mag;      // dividend bits shift out, quotient bits shift in
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic             busy;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial = {rem, mag[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
      done <= !start && busy && (cnt == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      mag <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DIV_W-1:0];
      end
      mag <= {mag[SUM_W-2:0], fits};
    end
  end

  assign quotient = neg ? -$signed(mag) : $signed(mag);

endmodule

// File: hdl/centered_window_average.sv
// Centered window average: top level with window sum, control and output register.
//
// Streams signed samples of one sequence and returns one result per position,
// delayed by the radius k: the sum of the 2k+1 samples centered there divided by
// 2k+1, truncated toward zero, or -1 where the window runs past either end. On
// tlast the remaining min(n,k) positions come out as -1, the final one with tlast.
// One item is worked at a time. With SUM_W = SAMPLE_WIDTH + $clog2(RADIUS_MAX+1) + 1
// (39 at the defaults), a request whose position has a full window goes through one
// memory read, the sum update in two adds, a step to load the serial divider, which
// then resolves one quotient bit per cycle, then the results one by one and a
// wrap-up state. A request whose results are all -1 skips the divider; a request
// with no result returns to idle after the sum update. A stalled output adds its
// stall. The output register lets a new request enter while the last result still
// waits downstream. Writing radius (saturated to RADIUS_MAX) is taken only between
// requests and aborts any sequence in progress; a pending radius write holds off
// new requests. The delay line needs no clearing after reset.
module centered_window_average #(
  parameter int RADIUS_MAX   = 63,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [cwa_pkg::FIELD_W-1:0] s_axis_tdata,   // [31:0] sample
  input  logic                        s_axis_tlast,   // last
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [cwa_pkg::FIELD_W-1:0] m_axis_tdata,   // [31:0] average
  output logic                        m_axis_tlast,   // last_res
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cwa_pkg::CFG_W-1:0]   cfg_radius
);

  import cwa_pkg::*;

  localparam int K_W    = $clog2(RADIUS_MAX + 1);
  localparam int WIN_W  = K_W + 1;
  localparam int SUM_W  = SAMPLE_WIDTH + WIN_W;
  localparam int ADDR_W = $clog2(2 * RADIUS_MAX + 2);

  state_t state;

  logic [K_W-1:0]          radius;
  logic [WIN_W-1:0]        win;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] samp;      // current sample, sign-extended
  logic [CNT_W-1:0]        seen;
  logic                    fin;       // current request ends the sequence
  logic                    old_full;  // a sample leaves the window this request
  logic [K_W-1:0]          flush_cnt;
  logic [ADDR_W-1:0]       wp;
  logic signed [SUM_W-1:0] res;

  logic                    in_acc;
  logic                    out_free;
  logic                    emit_now;
  logic [SAMPLE_WIDTH-1:0] rd_data;
  logic signed [SUM_W-1:0] rd_ext;
  logic signed [SUM_W-1:0] in_ext;
  logic                    div_start;
  logic                    div_done;
  logic signed [SUM_W-1:0] quotient;
  logic [K_W-1:0]          flush_len;
  logic                    main_res;
  logic                    full_win;

  assign win       = {radius, 1'b1};
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign emit_now  = out_free && (state == ST_EMIT || state == ST_FLUSH);
  assign s_axis_tready = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE);

  assign in_ext = SUM_W'($signed(s_axis_tdata[SAMPLE_WIDTH-1:0]));
  assign rd_ext = SUM_W'($signed(rd_data));

  // seen already counts the current sample from ST_SUB on
  assign main_res  = seen >= CNT_W'(radius) + CNT_W'(1);
  assign full_win  = seen >= CNT_W'(win);
  assign flush_len = !fin ? '0 : (seen < CNT_W'(radius)) ? K_W'(seen) : radius;

  cwa_delay_line #(
    .ADDR_W(ADDR_W),
    .DATA_W(SAMPLE_WIDTH)
  ) u_line (
    .clk    (clk),
    .wr_en  (in_acc),
    .wr_addr(wp),
    .wr_data(s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .rd_en  (in_acc),
    .rd_addr(wp - ADDR_W'(win)),          // sample 2k+1 requests ago
    .rd_data(rd_data)
  );

  // Divider starts on the first ST_DIV cycle, once the sum holds the new sample
  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= (state == ST_ADD) && main_res && full_win;
    end
  end

  cwa_divider #(
    .SUM_W(SUM_W),
    .DIV_W(WIN_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum),
    .divisor (win),
    .done    (div_done),
    .quotient(quotient)
  );

  // Control and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      radius        <= '0;
      sum           <= '0;
      seen          <= '0;
      wp            <= '0;
      flush_cnt     <= '0;
      fin           <= 1'b0;
      old_full      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (emit_now) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            samp     <= in_ext;
            fin      <= s_axis_tlast;
            old_full <= seen >= CNT_W'(win);
            seen     <= (seen == CNT_MAX) ? seen : seen + 1'b1;
            wp       <= wp + 1'b1;
            state    <= ST_SUB;
          end
        end
        ST_SUB: begin
          if (old_full) begin
            sum <= sum - rd_ext;
          end
          state <= ST_ADD;
        end
        ST_ADD: begin
          sum       <= sum + samp;
          flush_cnt <= flush_len;
          res       <= '1;
          if (main_res) begin
            state <= full_win ? ST_DIV : ST_EMIT;
          end else if (fin) begin
            state <= ST_FLUSH;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res   <= quotient;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_axis_tdata  <= FIELD_W'(res);
            m_axis_tlast  <= fin && (flush_cnt == '0);
            state         <= (flush_cnt == '0) ? ST_DONE : ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            m_axis_tdata  <= '1;
            m_axis_tlast  <= (flush_cnt == K_W'(1));
            flush_cnt     <= flush_cnt - 1'b1;
            if (flush_cnt == K_W'(1)) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          // end of sequence starts a fresh window
          if (fin) begin
            sum  <= '0;
            seen <= '0;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      // only in ST_IDLE, where no request is taken in the same cycle
      if (cfg_valid && cfg_ready) begin
        radius <= ({{(32 - CFG_W){1'b0}}, cfg_radius} > 32'(RADIUS_MAX)) ?
                  K_W'(RADIUS_MAX) : K_W'(cfg_radius);
        sum    <= '0;
        seen   <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_flush_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH |-> flush_cnt != '0 && flush_cnt <= radius)
    else $error("flush count out of range");

  a_seen_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUB |-> seen != '0)
    else $error("sample count not advanced on request");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_SUB)
    else $error("accepted request did not start the sum update");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the centered window average stream block.
module tb;

  import cwa_pkg::*;

  localparam int HISTORY_DEPTH = 128;      // one full window at the largest radius, plus one
  localparam int SETTLE_CYCLES = 100;      // lets the block settle after the last average
  localparam int CYCLE_LIMIT   = 5_000_000;

  typedef struct packed {
    logic [FIELD_W-1:0] average;
    logic               last_res;
  } average_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [FIELD_W-1:0] s_axis_tdata  = '0;   // [31:0] sample
  logic               s_axis_tlast  = 1'b0; // last
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [FIELD_W-1:0] m_axis_tdata;         // [31:0] average
  logic               m_axis_tlast;         // last_res
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_radius = '0;

  centered_window_average dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_radius    (cfg_radius)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Window model: sample history, running window sum, saturating count, radius.
  logic signed [FIELD_W-1:0] sample_history [HISTORY_DEPTH];
  logic signed [38:0]        window_sum   = '0;
  logic [CNT_W-1:0]          sample_count = '0;
  logic [CFG_W-1:0]          radius_k     = '0;

  average_result_t pending_averages [$];

  int  fail_count       = 0;
  int  samples_sent     = 0;
  int  averages_checked = 0;
  int  radius_writes    = 0;
  int  cycle_count      = 0;
  bit  burst_mode       = 1'b0;   // no gaps and no stalls while set
  int  sink_hold        = 0;

  // Mostly no gap, some short ones, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (burst_mode || r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Full-range values with the extremes and small values near zero mixed in.
  function automatic logic [FIELD_W-1:0] random_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h7FFF_FFFF;
    if (r == 1) return 32'h8000_0000;
    if (r == 2) return $urandom_range(0, 20) - 10;
    return $urandom;
  endfunction

  // Advance the window by one accepted sample and queue the averages it releases.
  function automatic void predict_averages(logic [FIELD_W-1:0] value, logic fin);
    int                 win;
    int                 flush;
    int                 produced;
    longint             mean;
    average_result_t    res;
    logic signed [FIELD_W-1:0] s;
    s        = value;
    win      = 2 * int'(radius_k) + 1;
    produced = 0;
    if (int'(sample_count) >= win) window_sum = window_sum - sample_history[win-1];
    for (int j = HISTORY_DEPTH - 1; j > 0; j--) sample_history[j] = sample_history[j-1];
    sample_history[0] = s;
    window_sum = window_sum + s;
    if (sample_count != CNT_MAX) sample_count = sample_count + 1'b1;

    // Center position c-1-k is ready once k samples past it have arrived.
    if (int'(sample_count) >= int'(radius_k) + 1) begin
      res.average  = '1;
      res.last_res = 1'b0;
      if (int'(sample_count) >= win) begin
        mean        = longint'(window_sum) / longint'(win);   // truncates toward zero
        res.average = mean[FIELD_W-1:0];
      end
      pending_averages.push_back(res);
      produced++;
    end

    // End of sequence: the tail positions have no full window.
    if (fin) begin
      flush = (int'(sample_count) < int'(radius_k)) ? int'(sample_count) : int'(radius_k);
      res.average  = '1;
      res.last_res = 1'b0;
      for (int j = 0; j < flush; j++) begin
        pending_averages.push_back(res);
        produced++;
      end
      if (produced > 0) pending_averages[pending_averages.size()-1].last_res = 1'b1;
      window_sum   = '0;
      sample_count = '0;
    end
  endfunction

  // One sample request; tvalid stays high on return so back-to-back requests have no bubble.
  task automatic send_sample(input logic [FIELD_W-1:0] value, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_averages(value, fin);
    samples_sent++;
  endtask

  // Drop the source, drain every pending average, then let the block settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A radius write also aborts any sequence in progress.
  task automatic write_radius(input logic [CFG_W-1:0] k);
    wait_idle();
    cfg_valid  <= 1'b1;
    cfg_radius <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    radius_k     = k;
    window_sum   = '0;
    sample_count = '0;
    radius_writes++;
  endtask

  // Radius left at its reset value: each sample is its own average.
  task automatic test_reset_radius();
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
  endtask

  // Radius 1: windows of both extremes, mixed signs, negative sums truncated toward zero.
  task automatic test_window_extremes();
    write_radius(6'd1);
    repeat (3) send_sample(32'h7FFF_FFFF, 1'b0);
    repeat (3) send_sample(32'h8000_0000, 1'b0);
    send_sample(32'd5, 1'b0);
    send_sample(-32'sd7, 1'b0);
    send_sample(32'd1, 1'b1);
  endtask

  // Sequences shorter than one window: every position comes out as -1.
  task automatic test_short_sequences();
    write_radius(6'd3);
    send_sample(32'h1234_5678, 1'b0);
    send_sample(32'hFEDC_BA98, 1'b1);
    for (int i = 0; i < 4; i++) send_sample(random_sample(), i == 3);
  endtask

  // A sequence left open is dropped by a radius write; the next one starts clean.
  task automatic test_abort_midsequence();
    write_radius(6'd2);
    for (int i = 0; i < 3; i++) send_sample(32'h7FFF_FFFF, 1'b0);
    write_radius(6'd2);
    for (int i = 0; i < 5; i++) send_sample(random_sample(), i == 4);
  endtask

  // Largest radius: a sequence just past one full window with a 63-result flush,
  // then a sequence too short for any full window.
  task automatic test_full_radius();
    write_radius(6'd63);
    for (int i = 0; i < 130; i++) send_sample(random_sample(), i == 129);
    for (int i = 0; i < 6; i++) send_sample(random_sample(), i == 5);
  endtask

  // Phases of random radius, each with a few sequences; some end without last.
  task automatic test_random_sequences();
    int               sent;
    int               phase;
    int               seqs;
    int               len;
    bit               broken;
    logic [CFG_W-1:0] k;
    sent  = 0;
    phase = 0;
    while (sent < 30) begin
      case (phase % 4)
        0:       k = '0;
        1:       k = CFG_W'($urandom_range(1, 4));
        2:       k = CFG_W'($urandom_range(5, 20));
        default: k = CFG_W'($urandom_range(0, 63));
      endcase
      write_radius(k);
      burst_mode = (phase % 3 == 2);
      seqs = $urandom_range(1, 3);
      for (int q = 0; q < seqs; q++) begin
        len = $urandom_range(1, 2 * int'(k) + 6);
        if (len > 12) len = $urandom_range(1, 12);
        broken = (q == seqs - 1) && ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++) begin
          send_sample(random_sample(), (i == len - 1) && !broken);
          sent++;
        end
      end
      burst_mode = 1'b0;
      phase++;
    end
  endtask

  // Result side: random stalls, and every accepted average checked in order.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_averages.size() == 0) begin
          $error("average %0d arrived with nothing pending", $signed(m_axis_tdata));
          fail_count++;
        end else begin
          if (m_axis_tdata !== pending_averages[0].average) begin
            $error("average: expected %0d, got %0d",
                   $signed(pending_averages[0].average), $signed(m_axis_tdata));
            fail_count++;
          end
          if (m_axis_tlast !== pending_averages[0].last_res) begin
            $error("last_res: expected %0b, got %0b",
                   pending_averages[0].last_res, m_axis_tlast);
            fail_count++;
          end
          void'(pending_averages.pop_front());
          averages_checked++;
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_hold = pick_gap();
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d averages pending",
               cycle_count, pending_averages.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_radius();
    test_window_extremes();
    test_short_sequences();
    test_abort_midsequence();
    test_full_radius();
    test_random_sequences();

    wait_idle();
    $display("%0d samples sent, %0d averages checked, %0d radius writes",
             samples_sent, averages_checked, radius_writes);
    $display("radius 0 through 63, extreme values, tail flushes and aborted sequences");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
